/* rtl/crec_pkg.sv */
// ============================================================================
// crec_pkg: chord recogniser shared types, tables and helpers
// Pitch-class constants, the chord pattern table and the records that travel
// between the cells and the output stage.
// ============================================================================
package crec_pkg;

    localparam int NUM_PITCHES  = 12;
    localparam int NUM_PATTERNS = 15;
    localparam int NOTE_W       = 4;
    localparam int TYPE_W       = 4;
    localparam int STATUS_W     = 2;
    localparam int FIRST_PLAIN  = 7;   // patterns from here on give no suggestions

    typedef logic [NUM_PITCHES-1:0] pmask_t;
    typedef logic [NOTE_W-1:0]      note_t;
    typedef logic [TYPE_W-1:0]      ctype_t;
    typedef logic [STATUS_W-1:0]    status_t;

    localparam status_t ST_NONE    = 2'd0;
    localparam status_t ST_SINGLE  = 2'd1;
    localparam status_t ST_CHORD   = 2'd2;
    localparam status_t ST_UNKNOWN = 2'd3;

    // Each pattern as the set of offsets above the root (running sum of gaps)
    localparam pmask_t PAT_MASK [NUM_PATTERNS] = '{
        12'h011,  // {4}
        12'h009,  // {3}
        12'h081,  // {7}
        12'h091,  // {4,3}
        12'h089,  // {3,4}
        12'h049,  // {3,3}
        12'h111,  // {4,4}
        12'h491,  // {4,3,3}
        12'h891,  // {4,3,4}
        12'h489,  // {3,4,3}
        12'h889,  // {3,4,4}
        12'h249,  // {3,3,3}
        12'h449,  // {3,3,4}
        12'h511,  // {4,4,2}
        12'h911   // {4,4,3}
    };

    localparam note_t SUG_FIRST [NUM_PATTERNS] = '{
        4'd7, 4'd7, 4'd4, 4'd10, 4'd10, 4'd9, 4'd10,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };

    localparam note_t SUG_SECOND [NUM_PATTERNS] = '{
        4'd8, 4'd6, 4'd3, 4'd11, 4'd11, 4'd10, 4'd11,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };

    localparam note_t SINGLE_FIRST  = 4'd4;
    localparam note_t SINGLE_SECOND = 4'd3;

    typedef struct packed {
        logic   hit;
        ctype_t idx;
    } pat_hit_t;

    // Record handed from cell to cell
    typedef struct packed {
        logic   valid;
        pmask_t rot;        // mask rotated so bit 0 is the candidate root
        note_t  cand;       // pitch class sitting at bit 0 of rot
        note_t  bass;
        logic   is_zero;
        logic   is_single;
        logic   found;
        note_t  root;
        ctype_t ctype;
    } cell_data_t;

    typedef struct packed {
        status_t status;
        note_t   root_note;
        note_t   bass_note;
        ctype_t  chord_type;
        logic    suggest_valid;
        note_t   suggest_first;
        note_t   suggest_second;
    } chord_res_t;

    function automatic pat_hit_t pat_lookup(input pmask_t m);
        pat_hit_t r;
        r.hit = 1'b0;
        r.idx = '0;
        for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
            if (m == PAT_MASK[p]) begin
                r.hit = 1'b1;
                r.idx = TYPE_W'(p);
            end
        end
        return r;
    endfunction

    function automatic note_t add_mod12(input note_t a, input note_t b);
        logic [NOTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (NOTE_W+1)'(NUM_PITCHES))
            s = s - (NOTE_W+1)'(NUM_PITCHES);
        return s[NOTE_W-1:0];
    endfunction

endpackage

/* rtl/crec_if.sv */
// ============================================================================
// crec_if: chord recogniser channel interfaces
// Valid/ready channels for the key mask input and the chord result output.
// ============================================================================
interface crec_key_if
    import crec_pkg::*;
();
    logic   valid;
    logic   ready;
    pmask_t key_mask;

    modport source (output valid, output key_mask, input ready);
    modport sink   (input valid, input key_mask, output ready);
endinterface

interface crec_chord_if
    import crec_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    note_t   root_note;
    note_t   bass_note;
    ctype_t  chord_type;
    logic    suggest_valid;
    note_t   suggest_first;
    note_t   suggest_second;

    modport source (output valid, output status, output root_note, output bass_note,
                    output chord_type, output suggest_valid, output suggest_first,
                    output suggest_second, input ready);
    modport sink   (input valid, input status, input root_note, input bass_note,
                    input chord_type, input suggest_valid, input suggest_first,
                    input suggest_second, output ready);
endinterface

/* rtl/crec_cell.sv */
// ============================================================================
// crec_cell: one root-candidate cell
// Try the pitch class at bit 0 as root, then rotate and hand on to the next.
// ============================================================================
module crec_cell
    import crec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  cell_data_t cell_i,
    output cell_data_t cell_o
);

    cell_data_t cell_reg;
    cell_data_t cell_next;
    pat_hit_t   hit;

    always_comb
    begin
        hit       = pat_lookup(cell_i.rot);
        cell_next = cell_i;
        // first matching root wins: hold an earlier match
        if (!cell_i.found && cell_i.rot[0] && hit.hit)
        begin
            cell_next.found = 1'b1;
            cell_next.root  = cell_i.cand;
            cell_next.ctype = hit.idx;
        end
        cell_next.rot  = {cell_i.rot[0], cell_i.rot[NUM_PITCHES-1:1]};
        cell_next.cand = cell_i.cand + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_o = cell_reg;

endmodule

/* rtl/crec_out.sv */
// ============================================================================
// crec_out: result stage
// Form status, root and suggested keys from the last cell and hold the item.
// ============================================================================
module crec_out
    import crec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  cell_data_t last_i,
    output logic       valid_o,
    output chord_res_t res_o
);

    logic       valid_reg;
    chord_res_t res_reg;
    chord_res_t res_next;

    always_comb
    begin
        res_next = '0;
        if (last_i.is_zero)
        begin
            res_next.status = ST_NONE;
        end
        else if (last_i.is_single)
        begin
            res_next.status         = ST_SINGLE;
            res_next.root_note      = last_i.bass;
            res_next.bass_note      = last_i.bass;
            res_next.suggest_valid  = 1'b1;
            res_next.suggest_first  = add_mod12(last_i.bass, SINGLE_FIRST);
            res_next.suggest_second = add_mod12(last_i.bass, SINGLE_SECOND);
        end
        else if (last_i.found)
        begin
            res_next.status     = ST_CHORD;
            res_next.root_note  = last_i.root;
            res_next.bass_note  = last_i.bass;
            res_next.chord_type = last_i.ctype;
            if (last_i.ctype < TYPE_W'(FIRST_PLAIN))
            begin
                res_next.suggest_valid  = 1'b1;
                res_next.suggest_first  = add_mod12(last_i.root, SUG_FIRST[last_i.ctype]);
                res_next.suggest_second = add_mod12(last_i.root, SUG_SECOND[last_i.ctype]);
            end
        end
        else
        begin
            res_next.status    = ST_UNKNOWN;
            res_next.bass_note = last_i.bass;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= last_i.valid;
            res_reg   <= res_next;
        end
    end

    assign valid_o = valid_reg;
    assign res_o   = res_reg;

endmodule

/* rtl/chord_recognizer.sv */
// ============================================================================
// chord_recognizer: pitch-class chord recogniser
// Classifies a 12-bit mask of pressed pitch classes as no key, single note,
// known chord or unknown, using a chain of twelve root-candidate cells.
// ============================================================================
//
//  channel    | dir | handshake    | payload
//  -----------+-----+--------------+------------------------------------------
//  key_in     | in  | valid/ready  | key_mask[11:0]
//  chord_out  | out | valid/ready  | status, root_note, bass_note, chord_type,
//             |     |              | suggest_valid, suggest_first, suggest_second
//
//  One item enters per cycle while the output is not stalled; each result
//  passes through the twelve cells of the chain and then the result register.
//  The whole chain moves together: it advances whenever the result register
//  is empty or being taken, so a stalled output holds every stage and drops
//  key_in.ready in the same cycle.
//  Reset clears the valid bit of every stage; payload is not reset.
//
module chord_recognizer
    import crec_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    crec_key_if.sink      key_in,
    crec_chord_if.source  chord_out
);

    // chain[k] feeds cell k; chain[NUM_PITCHES] feeds the result stage
    cell_data_t chain [NUM_PITCHES+1];
    cell_data_t front;
    chord_res_t res;
    logic       out_valid;
    logic       advance;
    pmask_t     mask;
    pmask_t     mask_low;

    // Advance the whole chain when the result register can take a new item
    assign advance      = !out_valid || chord_out.ready;
    assign key_in.ready = advance;

    assign mask     = key_in.key_mask;
    // mask with its lowest set bit cleared: zero means at most one note
    assign mask_low = mask & (mask - 1'b1);

    // Front end: bass note and the no-key / single-note flags
    always_comb
    begin
        front           = '0;
        front.valid     = key_in.valid;
        front.rot       = mask;
        front.cand      = '0;
        front.is_zero   = (mask == '0);
        front.is_single = (mask != '0) && (mask_low == '0);
        for (int k = NUM_PITCHES - 1; k >= 0; k--)
        begin
            if (mask[k])
                front.bass = NOTE_W'(k);
        end
    end

    assign chain[0] = front;

    // One cell for each candidate root, in ascending pitch order
    for (genvar g = 0; g < NUM_PITCHES; g++)
    begin : g_cell
        crec_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .cell_i  (chain[g]),
            .cell_o  (chain[g+1])
        );
    end

    crec_out u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .last_i  (chain[NUM_PITCHES]),
        .valid_o (out_valid),
        .res_o   (res)
    );

    assign chord_out.valid          = out_valid;
    assign chord_out.status         = res.status;
    assign chord_out.root_note      = res.root_note;
    assign chord_out.bass_note      = res.bass_note;
    assign chord_out.chord_type     = res.chord_type;
    assign chord_out.suggest_valid  = res.suggest_valid;
    assign chord_out.suggest_first  = res.suggest_first;
    assign chord_out.suggest_second = res.suggest_second;

`ifndef NO_ASSERTIONS
    // A held result must stall the input side
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        chord_out.valid && !chord_out.ready |-> !key_in.ready)
        else $error("input accepted while result stalled");

    // No key gives an all-zero result
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        chord_out.valid && chord_out.status == ST_NONE |->
            chord_out.root_note == '0 && chord_out.bass_note == '0 &&
            !chord_out.suggest_valid && chord_out.chord_type == '0)
        else $error("no-key result carries data");

    // A single note is its own root and bass
    a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
        chord_out.valid && chord_out.status == ST_SINGLE |->
            chord_out.root_note == chord_out.bass_note && chord_out.suggest_valid)
        else $error("single note result inconsistent");

    // Matched chords use a table entry; suggestions only for the short patterns
    a_chord_type: assert property (@(posedge clk) disable iff (!rst_n)
        chord_out.valid && chord_out.status == ST_CHORD |->
            chord_out.chord_type < TYPE_W'(NUM_PATTERNS) &&
            chord_out.suggest_valid == (chord_out.chord_type < TYPE_W'(FIRST_PLAIN)))
        else $error("chord type or suggestion flag out of place");

    // Unknown keeps only the bass note
    a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        chord_out.valid && chord_out.status == ST_UNKNOWN |->
            chord_out.root_note == '0 && !chord_out.suggest_valid &&
            chord_out.chord_type == '0)
        else $error("unknown result carries chord data");
`endif

endmodule
